>>> sv/slrx_pkg.sv
// Shared types and constants for the SLIP receive deframer with raw ring.
package slrx_pkg;

  localparam int unsigned PacketMaxDef = 512;
  localparam int unsigned RingDepthDef = 256;

  localparam logic [7:0] SLIP_END     = 8'hC0;
  localparam logic [7:0] SLIP_ESC     = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

  localparam logic [1:0] ACT_RX    = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_DATA  = 3'd1;
  localparam logic [2:0] KIND_END   = 3'd2;
  localparam logic [2:0] KIND_RAW   = 3'd3;
  localparam logic [2:0] KIND_EMPTY = 3'd4;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic       buffer_granted;
  } slrx_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  byte_value;
    logic [9:0]  packet_length;
    logic [15:0] dropped_count;
    logic [7:0]  ring_level;
  } slrx_out_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clr;
    logic [7:0] wdata;
  } slrx_ring_req_t;

  typedef struct packed {
    logic       empty;
    logic [7:0] level;
  } slrx_ring_rsp_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  value;
    logic [9:0]  length;
    logic [15:0] drops;
  } slrx_dec_res_t;

endpackage

>>> sv/slrx_ram.sv
// Generic single-write, single-read RAM with registered read data.
module slrx_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/slrx_decoder.sv
// SLIP frame decoder: packet open/escape state, length and overflow counters.
module slrx_decoder import slrx_pkg::*; #(
  parameter int unsigned PacketMax = PacketMaxDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  slrx_in_t       item_i,
  output slrx_dec_res_t  res_o,
  output slrx_ring_req_t ring_req_o
);

  localparam int unsigned LenW = $clog2(PacketMax + 1);

  logic            open_q, open_d;
  logic            esc_q, esc_d;
  logic [LenW-1:0] len_q, len_d;
  logic [15:0]     drops_q, drops_d;
  logic [7:0]      dec_byte;
  logic [31:0]     len_ext;

  assign len_ext = 32'(len_q);

  always_comb begin
    open_d     = open_q;
    esc_d      = esc_q;
    len_d      = len_q;
    drops_d    = drops_q;
    res_o      = '0;
    ring_req_o = '0;
    dec_byte   = item_i.rx_byte;

    unique case (item_i.action)
      ACT_RX: begin
        if (item_i.rx_byte == SLIP_END) begin
          if (!open_q) begin
            if (item_i.buffer_granted) begin
              open_d  = 1'b1;
              esc_d   = 1'b0;
              len_d   = '0;
              drops_d = '0;
            end
          end else if (len_q != '0) begin
            res_o.kind   = KIND_END;
            res_o.length = (len_ext > 32'd1023) ? 10'd1023 : len_ext[9:0];
            res_o.drops  = drops_q;
            open_d       = 1'b0;
            esc_d        = 1'b0;
            len_d        = '0;
          end
        end else if (open_q) begin
          if (item_i.rx_byte == SLIP_ESC) begin
            esc_d = 1'b1;
          end else begin
            if (esc_q && item_i.rx_byte == SLIP_ESC_END) begin
              dec_byte = SLIP_END;
            end else if (esc_q && item_i.rx_byte == SLIP_ESC_ESC) begin
              dec_byte = SLIP_ESC;
            end
            esc_d = 1'b0;
            if (len_q < LenW'(PacketMax)) begin
              len_d       = len_q + LenW'(1);
              res_o.kind  = KIND_DATA;
              res_o.value = dec_byte;
            end else if (drops_q != 16'hFFFF) begin
              drops_d = drops_q + 16'd1;
            end
          end
        end else begin
          // outside a frame: hand the byte to the raw ring
          ring_req_o.push  = en_i;
          ring_req_o.wdata = item_i.rx_byte;
        end
      end
      ACT_READ: begin
        ring_req_o.pop = en_i;
      end
      ACT_CLEAR: begin
        open_d         = 1'b0;
        esc_d          = 1'b0;
        len_d          = '0;
        drops_d        = '0;
        ring_req_o.clr = en_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      esc_q   <= 1'b0;
      len_q   <= '0;
      drops_q <= '0;
    end else if (en_i) begin
      open_q  <= open_d;
      esc_q   <= esc_d;
      len_q   <= len_d;
      drops_q <= drops_d;
    end
  end

endmodule

>>> sv/slrx_ring.sv
// Raw byte ring: head/tail pointers around a registered-read RAM.
module slrx_ring import slrx_pkg::*; #(
  parameter int unsigned RingDepth = RingDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  slrx_ring_req_t req_i,
  output slrx_ring_rsp_t rsp_o,
  output logic [7:0]     rdata_o
);

  localparam int unsigned PtrW = $clog2(RingDepth);

  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [PtrW-1:0] head_nx, tail_nx;
  logic            full, empty, do_push, do_pop;
  logic [PtrW:0]   cnt;

  assign head_nx = (head_q == PtrW'(RingDepth - 1)) ? '0 : head_q + PtrW'(1);
  assign tail_nx = (tail_q == PtrW'(RingDepth - 1)) ? '0 : tail_q + PtrW'(1);
  assign full    = (head_nx == tail_q);
  assign empty   = (head_q == tail_q);
  assign do_push = req_i.push && !full;
  assign do_pop  = req_i.pop && !empty;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (req_i.clr) begin
      head_d = '0;
      tail_d = '0;
    end else begin
      if (do_push) begin
        head_d = head_nx;
      end
      if (do_pop) begin
        tail_d = tail_nx;
      end
    end
    cnt = {1'b0, head_d} - {1'b0, tail_d};
    if (head_d < tail_d) begin
      cnt = cnt + (PtrW + 1)'(RingDepth);
    end
  end

  assign rsp_o.empty = empty;
  assign rsp_o.level = (32'(cnt) > 32'd255) ? 8'hFF : 8'(cnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  slrx_ram #(
    .Width(8),
    .Depth(RingDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (do_push),
    .waddr_i(head_q),
    .wdata_i(req_i.wdata),
    .re_i   (do_pop),
    .raddr_i(tail_q),
    .rdata_o(rdata_o)
  );

`ifndef ASSERT_OFF
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(head_q) < RingDepth)
    else $error("ring head out of range");
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.push && full && !req_i.clr) |=> $stable(head_q))
    else $error("push into full ring moved head");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.pop && empty && !req_i.clr) |=> $stable(tail_q))
    else $error("pop from empty ring moved tail");
`endif

endmodule

>>> sv/slip_rx_deframer_with_raw_ring_unit.sv
// A result word is registered and appears on the output in the cycle after its input word is accepted.
// Throughput: one word per cycle; a word is taken whenever the output register is free or drains.
// Raw ring bytes come from a registered-read RAM, read in the accept cycle.
// Reset clears the frame flags, counters and ring pointers; ring contents are not cleared.
module slip_rx_deframer_with_raw_ring_unit import slrx_pkg::*; #(
  parameter int unsigned PacketMax = PacketMaxDef,
  parameter int unsigned RingDepth = RingDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  slrx_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output slrx_out_t out_data_o
);

  logic           accept;
  logic           out_valid_q;
  logic           raw_sel_q;
  slrx_out_t      res_q, res_d;
  slrx_dec_res_t  dec_res;
  slrx_ring_req_t ring_req;
  slrx_ring_rsp_t ring_rsp;
  logic [7:0]     ring_rdata;
  logic           is_read;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_read    = (in_data_i.action == ACT_READ);

  slrx_decoder #(
    .PacketMax(PacketMax)
  ) u_decoder (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (accept),
    .item_i    (in_data_i),
    .res_o     (dec_res),
    .ring_req_o(ring_req)
  );

  slrx_ring #(
    .RingDepth(RingDepth)
  ) u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ring_req),
    .rsp_o  (ring_rsp),
    .rdata_o(ring_rdata)
  );

  always_comb begin
    res_d.kind          = dec_res.kind;
    res_d.byte_value    = dec_res.value;
    res_d.packet_length = dec_res.length;
    res_d.dropped_count = dec_res.drops;
    res_d.ring_level    = ring_rsp.level;
    if (is_read) begin
      res_d.kind = ring_rsp.empty ? KIND_EMPTY : KIND_RAW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // hold the result word while stalled; RAM read data holds since no new read issues
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q     <= res_d;
      raw_sel_q <= is_read && !ring_rsp.empty;
    end
  end

  always_comb begin
    out_data_o = res_q;
    if (raw_sel_q) begin
      out_data_o.byte_value = ring_rdata;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_read_gives_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_read && !ring_rsp.empty) |=> (out_valid_o && out_data_o.kind == KIND_RAW))
    else $error("read of non-empty ring did not return a raw byte");
  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.action == ACT_CLEAR)
      |=> (out_data_o.kind == KIND_NONE && out_data_o.ring_level == 8'd0))
    else $error("clear did not empty the receiver");
  a_end_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == KIND_END) |-> (out_data_o.packet_length != 10'd0))
    else $error("packet end reported with zero length");
`endif

endmodule
